// File: design/lsct_pkg.sv
// ----------------------------------------------------------------------------
// Line sensor centroid tracker package
// Shared widths, register indexes and state codes.
// ----------------------------------------------------------------------------
package lsct_pkg;
  localparam int unsigned NumSensors    = 7;
  localparam int unsigned SampleBits    = 12;
  localparam int unsigned SensorSpacing = 1000;
  localparam int unsigned PosBits       = 17;
  localparam int unsigned CfgBits       = 16;
  localparam int unsigned SensIdxBits   = $clog2(NumSensors);
  localparam int unsigned CfgIdxBits    = 1;

  localparam logic [CfgIdxBits-1:0] RegSmoothCoeff = 1'd0;
  localparam logic [CfgIdxBits-1:0] RegWeightThr   = 1'd1;

  localparam logic OpCalibrate = 1'b0;
  localparam logic OpTrack     = 1'b1;

  typedef logic [SampleBits-1:0] sample_t;

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StWDiv,
    StWSq,
    StCDiv,
    StMix,
    StOut
  } state_e;
endpackage

// File: design/lsct_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload of the given type with a source and a sink side.
// ----------------------------------------------------------------------------
interface lsct_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/lsct_in_pkg.sv
// ----------------------------------------------------------------------------
// Line sensor centroid tracker payload types
// Input and result item layouts.
// ----------------------------------------------------------------------------
package lsct_in_pkg;
  typedef struct packed {
    logic        op;
    logic [11:0] sample_0;
    logic [11:0] sample_1;
    logic [11:0] sample_2;
    logic [11:0] sample_3;
    logic [11:0] sample_4;
    logic [11:0] sample_5;
    logic [11:0] sample_6;
  } in_item_t;

  typedef struct packed {
    logic [16:0] line_position;
    logic        position_updated;
  } out_item_t;
endpackage

// File: design/line_sensor_centroid_tracker.sv
// ----------------------------------------------------------------------------
// Line sensor centroid tracker
// Calibrates per-sensor bounds and tracks a smoothed weighted line centroid.
// ----------------------------------------------------------------------------
// A calibrate item goes to the output state, which then registers the result
// valid; a track item does setup, weight division and squaring per sensor, then
// centroid division, mix (not on a zero weight sum) and output, on the one
// shared restoring divider (one quotient bit a cycle) and bit-serial multiplier.
// Throughput: one item at a time; the next item is taken the cycle after the
// result transfer. Reset sets the bounds to their empty span, the position
// to zero and the registers to their defaults; no clearing pass is needed.
module line_sensor_centroid_tracker (
  input  logic clk_i,
  input  logic rst_ni,
  lsct_stream_if.sink   in_if,
  lsct_stream_if.source out_if,
  input  logic                          cfg_we_i,
  input  logic [lsct_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [lsct_pkg::CfgBits-1:0]  cfg_data_i
);
  import lsct_pkg::*;
  import lsct_in_pkg::*;

  // Division layout: a 40-bit dividend against a 40-bit divisor, one
  // quotient bit per cycle. The weight division needs 17 quotient bits
  // (fold magnitude times 2^16 over the span, capped at 65536), the
  // centroid division needs the position bits plus one saturation bit.
  localparam int unsigned DivBits = 40;
  localparam int unsigned CntBits = 6;
  // Squaring: a load step, 17 multiply steps, an accumulate step.
  localparam int unsigned WSqCycles = 18;
  // Mixing: load, 16 steps for coeff*old, reload, 17 steps, an update step.
  localparam int unsigned MixCycles = 35;
  localparam int unsigned MixReload = 18;

  state_e state_q, state_d;

  logic [CfgBits-1:0] coeff_q, thr_q;
  sample_t min_q [NumSensors];
  sample_t max_q [NumSensors];
  logic [PosBits-1:0] pos_q;

  in_item_t item_q;
  logic [SensIdxBits-1:0] idx_q;
  logic [CntBits-1:0] cnt_q;

  // Shared shift-subtract unit.
  logic [DivBits-1:0] rem_q, quo_q, dvs_q;
  // Bit-serial multiplier: multiplier shifts right, product accumulates.
  logic [DivBits-1:0] mcand_q, mplier_q, prod_q;

  logic [23:0] sum_q;     // sum of seven Q0.16 weights
  logic [39:0] mom_q;     // weighted moments
  logic        zero_w_q;  // weight forced to zero for this sensor

  out_item_t out_q;
  logic      out_valid_q;

  // Current sensor sample.
  sample_t cur_v;
  always_comb begin
    unique case (idx_q)
      3'd0:    cur_v = item_q.sample_0;
      3'd1:    cur_v = item_q.sample_1;
      3'd2:    cur_v = item_q.sample_2;
      3'd3:    cur_v = item_q.sample_3;
      3'd4:    cur_v = item_q.sample_4;
      3'd5:    cur_v = item_q.sample_5;
      default: cur_v = item_q.sample_6;
    endcase
  end

  // Samples of the incoming item, used by calibration.
  sample_t in_smp [NumSensors];
  always_comb begin
    in_smp[0] = in_if.payload.sample_0;
    in_smp[1] = in_if.payload.sample_1;
    in_smp[2] = in_if.payload.sample_2;
    in_smp[3] = in_if.payload.sample_3;
    in_smp[4] = in_if.payload.sample_4;
    in_smp[5] = in_if.payload.sample_5;
    in_smp[6] = in_if.payload.sample_6;
  end

  // Fold magnitude and span for the current sensor.
  logic [SampleBits:0] span, dif_lo, mag;
  logic                degenerate, neg_zero;
  always_comb begin
    span       = {1'b0, max_q[idx_q]} - {1'b0, min_q[idx_q]};
    degenerate = (max_q[idx_q] <= min_q[idx_q]);
    neg_zero   = 1'b0;
    if (cur_v < min_q[idx_q]) begin
      dif_lo = {1'b0, min_q[idx_q]} - {1'b0, cur_v};
      if (dif_lo >= span) begin
        neg_zero = 1'b1;
      end
      mag = span - dif_lo;
    end else begin
      dif_lo = {1'b0, cur_v} - {1'b0, min_q[idx_q]};
      mag = (dif_lo > span) ? dif_lo - span : span - dif_lo;
    end
  end

  // One restoring division step.
  logic [DivBits:0] trial;
  logic [DivBits-1:0] rem_sh, rem_nx, quo_nx;
  always_comb begin
    rem_sh = {rem_q[DivBits-2:0], quo_q[DivBits-1]};
    trial  = {1'b0, rem_sh} - {1'b0, dvs_q};
    if (!trial[DivBits]) begin
      rem_nx = trial[DivBits-1:0];
      quo_nx = {quo_q[DivBits-2:0], 1'b1};
    end else begin
      rem_nx = rem_sh;
      quo_nx = {quo_q[DivBits-2:0], 1'b0};
    end
  end

  // One multiply step.
  logic [DivBits-1:0] prod_step;
  assign prod_step = mplier_q[0] ? prod_q + mcand_q : prod_q;

  // Thresholded weight of the finished square and the running sums with it.
  logic [23:0] w_eff, sum_nx;
  logic [39:0] mom_nx;
  always_comb begin
    w_eff = prod_q[39:16];
    if (zero_w_q || (prod_q[39:16] < {8'b0, thr_q})) begin
      w_eff = '0;
    end
    sum_nx = sum_q + w_eff;
    mom_nx = mom_q + 40'(w_eff) * 40'(idx_q) * 40'(SensorSpacing);
  end

  logic in_fire, out_fire;
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign in_if.ready = (state_q == StIdle) && !out_valid_q;
  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

  // Capped fold value.
  logic [16:0] f_cap;
  assign f_cap = (quo_q[DivBits-1:17] != '0 || quo_q[16:0] > 17'h10000) ?
                 17'h10000 : quo_q[16:0];

  logic [DivBits-1:0] raw_sat;
  assign raw_sat = (quo_q > 40'd131071) ? 40'd131071 : quo_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_fire) state_d = (in_if.payload.op == OpTrack) ? StSetup : StOut;
      StSetup: state_d = StWDiv;
      StWDiv:  if (cnt_q == '0) state_d = StWSq;
      StWSq:   if (cnt_q == '0) begin
        if (idx_q == SensIdxBits'(NumSensors - 1)) state_d = StCDiv;
        else state_d = StSetup;
      end
      StCDiv:  if (cnt_q == '0) state_d = (sum_q == '0) ? StOut : StMix;
      StMix:   if (cnt_q == '0) state_d = StOut;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      coeff_q     <= '0;
      thr_q       <= CfgBits'(26214);
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumSensors; i++) begin
        min_q[i] <= '1;
        max_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegSmoothCoeff) coeff_q <= cfg_data_i;
        else if (cfg_idx_i == RegWeightThr) thr_q <= cfg_data_i;
      end
      if (out_fire) out_valid_q <= 1'b0;
      if (state_q == StIdle && in_fire && in_if.payload.op == OpCalibrate) begin
        for (int i = 0; i < NumSensors; i++) begin
          if (in_smp[i] > max_q[i]) max_q[i] <= in_smp[i];
          if (in_smp[i] < min_q[i]) min_q[i] <= in_smp[i];
        end
      end
      if (state_q == StMix && cnt_q == '0) begin
        // Rounded mix; cannot exceed the 17-bit range of its inputs.
        pos_q <= PosBits'((prod_q + 40'd32768) >> 16);
      end
      if (state_q == StOut) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          item_q <= in_if.payload;
          idx_q  <= '0;
          sum_q  <= '0;
          mom_q  <= '0;
          out_q.position_updated <= 1'b0;
        end
      end
      StSetup: begin
        zero_w_q <= degenerate || neg_zero;
        rem_q    <= '0;
        quo_q    <= DivBits'({mag, 16'b0});
        dvs_q    <= DivBits'(span);
        cnt_q    <= CntBits'(DivBits - 1);
      end
      StWDiv: begin
        rem_q <= rem_nx;
        quo_q <= quo_nx;
        cnt_q <= (cnt_q == '0) ? CntBits'(WSqCycles) : cnt_q - CntBits'(1);
      end
      StWSq: begin
        if (cnt_q == CntBits'(WSqCycles)) begin
          mcand_q  <= DivBits'(f_cap);
          mplier_q <= DivBits'(f_cap);
          prod_q   <= '0;
        end else if (cnt_q != '0) begin
          prod_q   <= prod_step;
          mcand_q  <= {mcand_q[DivBits-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[DivBits-1:1]};
        end
        if (cnt_q == '0) begin
          // prod_q now holds f*f; the weight is its upper part.
          sum_q <= sum_nx;
          mom_q <= mom_nx;
          idx_q <= idx_q + SensIdxBits'(1);
          cnt_q <= CntBits'(DivBits - 1);
          // Load the centroid division when leaving the last sensor.
          if (idx_q == SensIdxBits'(NumSensors - 1)) begin
            rem_q <= '0;
            quo_q <= mom_nx << 4;
            dvs_q <= DivBits'(sum_nx);
          end
        end else begin
          cnt_q <= cnt_q - CntBits'(1);
        end
      end
      StCDiv: begin
        rem_q <= rem_nx;
        quo_q <= quo_nx;
        cnt_q <= (cnt_q == '0) ? CntBits'(MixCycles) : cnt_q - CntBits'(1);
      end
      StMix: begin
        // Two serial products: coeff*old in 16 steps, then (1-coeff)*raw in 17.
        if (cnt_q == CntBits'(MixCycles)) begin
          prod_q   <= '0;
          mcand_q  <= DivBits'(pos_q);
          mplier_q <= DivBits'(coeff_q);
          quo_q    <= raw_sat;
        end else if (cnt_q == CntBits'(MixReload)) begin
          mcand_q  <= quo_q;
          mplier_q <= DivBits'(18'h10000 - {2'b0, coeff_q});
        end else if (cnt_q != '0) begin
          prod_q   <= prod_step;
          mcand_q  <= {mcand_q[DivBits-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[DivBits-1:1]};
        end
        cnt_q <= cnt_q - CntBits'(1);
        out_q.position_updated <= 1'b1;
      end
      StOut: begin
        out_q.line_position <= pos_q;
      end
      default: ;
    endcase
  end
endmodule

// File: bench/line_sensor_centroid_tracker_test.sv
// ----------------------------------------------------------------------------
// Line sensor centroid tracker testbench
// Drives calibrate and track items through the stream channels, predicts
// each result with a cycle-free model of the fixed-point tracker and checks
// every result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module line_sensor_centroid_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lsct_pkg::*;
  import lsct_in_pkg::*;

  // Cycles in which no transfer happens before the run is declared hung.
  // It covers a whole track item plus sender gaps and receiver stalls.
  localparam int unsigned HangLimit = 20000;
  // Cycles to let pass after the last result.
  localparam int unsigned DrainCycles = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [CfgBits-1:0] cfg_data_i = '0;

  lsct_stream_if #(.payload_t(in_item_t))  in_ch ();
  lsct_stream_if #(.payload_t(out_item_t)) out_ch ();

  line_sensor_centroid_tracker DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Tracker state as the bench sees it. It advances when an item is accepted.
  logic [15:0]         smooth_coeff;
  logic [15:0]         weight_thr;
  sample_t             bound_lo [NumSensors];
  sample_t             bound_hi [NumSensors];
  logic [PosBits-1:0]  track_pos;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int unsigned mismatches = 0;
  bit          timed_out = 1'b0;
  // Set at a rising edge where the presented item was transferred.
  bit          in_taken = 1'b0;
  // Each side idles only while its flag is set; cleared for a calm stretch.
  bit          send_gaps = 1'b1;
  bit          recv_stalls = 1'b1;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("Mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Q0.16 weight of one sensor after folding, squaring and thresholding.
  function automatic longint unsigned fold_weight(input sample_t v, input sample_t lo,
                                                  input sample_t hi);
    longint den, offs, num;
    longint unsigned mag, frac, sq;
    if (hi <= lo) return 0;
    den  = longint'(hi) - longint'(lo);
    offs = longint'(v) - longint'(lo);
    if (offs < 0) begin
      num = den + offs;
      if (num <= 0) return 0;
      mag = num;
    end else begin
      num = den - offs;
      mag = (num < 0) ? -num : num;
    end
    frac = (mag * 65536) / den;
    if (frac > 65536) frac = 65536;
    sq = (frac * frac) >> 16;
    if (sq < weight_thr) sq = 0;
    return sq;
  endfunction

  // Applies one accepted item to the bench state and returns its result.
  function automatic out_item_t track_item(input in_item_t it);
    sample_t s [NumSensors];
    longint unsigned wsum, moment, w, raw, mix;
    out_item_t r;
    s = '{it.sample_0, it.sample_1, it.sample_2, it.sample_3,
          it.sample_4, it.sample_5, it.sample_6};
    r.position_updated = 1'b0;
    if (it.op == OpCalibrate) begin
      // Both bounds are widened independently.
      for (int i = 0; i < NumSensors; i++) begin
        if (s[i] > bound_hi[i]) bound_hi[i] = s[i];
        if (s[i] < bound_lo[i]) bound_lo[i] = s[i];
      end
    end else begin
      wsum = 0;
      moment = 0;
      for (int i = 0; i < NumSensors; i++) begin
        w = fold_weight(s[i], bound_lo[i], bound_hi[i]);
        wsum += w;
        moment += w * i * SensorSpacing;
      end
      // A zero weight sum holds the position.
      if (wsum != 0) begin
        raw = (moment * 16) / wsum;
        if (raw > 131071) raw = 131071;
        mix = (longint'(smooth_coeff) * track_pos
               + (65536 - longint'(smooth_coeff)) * raw + 32768) >> 16;
        if (mix > 131071) mix = 131071;
        track_pos = mix;
        r.position_updated = 1'b1;
      end
    end
    r.line_position = track_pos;
    return r;
  endfunction

  // Driver: presents queued items at the falling edge, with random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= '0;
    end else if (in_ch.valid && !in_taken) begin
      // Hold the item until it is accepted.
    end else if (pending_items.size() > 0 && !(send_gaps && $urandom_range(99) < 30)) begin
      in_ch.valid <= 1'b1;
      in_ch.payload <= pending_items.pop_front();
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= !(recv_stalls && $urandom_range(99) < 30);
  end

  // Monitor: predicts on input transfers and checks result transfers.
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) expected_results.push_back(track_item(in_ch.payload));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, line_position", out_ch.payload.line_position, -1);
        end else begin
          out_item_t want;
          want = expected_results.pop_front();
          if (out_ch.payload.line_position !== want.line_position)
            report_mismatch("line_position", out_ch.payload.line_position, want.line_position);
          if (out_ch.payload.position_updated !== want.position_updated)
            report_mismatch("position_updated", out_ch.payload.position_updated,
                            want.position_updated);
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (pending_items.size() == 0 && expected_results.size() == 0 && !in_ch.valid)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= HangLimit) begin
        timed_out = 1'b1;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (timed_out) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic in_item_t make_item(input logic op, input sample_t s0, input sample_t s1,
                                         input sample_t s2, input sample_t s3,
                                         input sample_t s4, input sample_t s5,
                                         input sample_t s6);
    in_item_t it;
    it.op = op;
    it.sample_0 = s0; it.sample_1 = s1; it.sample_2 = s2; it.sample_3 = s3;
    it.sample_4 = s4; it.sample_5 = s5; it.sample_6 = s6;
    return it;
  endfunction

  function automatic sample_t rnd_sample();
    return sample_t'($urandom_range(4095));
  endfunction

  function automatic in_item_t random_item(input logic op);
    return make_item(op, rnd_sample(), rnd_sample(), rnd_sample(), rnd_sample(),
                     rnd_sample(), rnd_sample(), rnd_sample());
  endfunction

  // A track item that mostly stays inside the calibrated span, with a dark
  // region around one sensor so the centroid moves.
  function automatic in_item_t line_item();
    sample_t s [NumSensors];
    int c;
    c = $urandom_range(NumSensors - 1);
    for (int i = 0; i < NumSensors; i++) begin
      if ($urandom_range(9) == 0) s[i] = rnd_sample();
      else if (i == c || (i - c == 1) || (c - i == 1))
        s[i] = sample_t'(bound_lo[i] + ((bound_hi[i] - bound_lo[i]) * $urandom_range(30)) / 100);
      else s[i] = sample_t'(bound_hi[i] - ((bound_hi[i] - bound_lo[i]) * $urandom_range(20)) / 100);
    end
    return make_item(OpTrack, s[0], s[1], s[2], s[3], s[4], s[5], s[6]);
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Register writes happen only while the block is idle, at a falling edge.
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegSmoothCoeff) smooth_coeff = val;
    else weight_thr = val;
  endtask

  initial begin
    logic [15:0] coeffs [4];
    logic [15:0] thrs [4];
    smooth_coeff = 16'd0;
    weight_thr = 16'd26214;
    for (int i = 0; i < NumSensors; i++) begin
      bound_lo[i] = '1;
      bound_hi[i] = '0;
    end
    track_pos = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: track before calibration sees degenerate bounds everywhere.
    pending_items.push_back(make_item(OpTrack, 0, 4095, 0, 4095, 0, 4095, 0));
    // Calibrate both extremes; each item sets one bound of every sensor.
    pending_items.push_back(make_item(OpCalibrate, 0, 0, 0, 0, 0, 0, 4095));
    pending_items.push_back(make_item(OpCalibrate, 4095, 4095, 4095, 4095, 4095, 4095, 0));
    pending_items.push_back(make_item(OpTrack, 0, 4095, 4095, 4095, 4095, 4095, 4095));
    pending_items.push_back(make_item(OpTrack, 4095, 4095, 4095, 4095, 4095, 4095, 0));
    pending_items.push_back(make_item(OpTrack, 4095, 4095, 4095, 0, 4095, 4095, 4095));
    pending_items.push_back(make_item(OpTrack, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OpTrack, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
    pending_items.push_back(make_item(OpTrack, 2048, 1024, 3000, 100, 4000, 2047, 1));
    pending_items.push_back(make_item(OpCalibrate, 2730, 1365, 2730, 1365, 2730, 1365, 2730));
    wait_drained();

    // Extreme register settings on the full calibrated span.
    write_reg(RegSmoothCoeff, 16'hFFFF);
    write_reg(RegWeightThr, 16'd0);
    for (int i = 0; i < NumSensors; i++) begin
      bound_lo[i] = bound_lo[i];
    end
    pending_items.push_back(make_item(OpTrack, 0, 4095, 2000, 1000, 3000, 0, 4095));
    pending_items.push_back(make_item(OpTrack, 4095, 0, 0, 0, 0, 0, 0));
    wait_drained();
    write_reg(RegSmoothCoeff, 16'd0);
    write_reg(RegWeightThr, 16'hFFFF);
    pending_items.push_back(make_item(OpTrack, 0, 4095, 0, 4095, 0, 4095, 0));
    pending_items.push_back(make_item(OpTrack, 4095, 0, 4095, 0, 4095, 0, 4095));
    wait_drained();

    // Random phases, each with its own register setting. A reset happens once,
    // so later phases recalibrate on top of the wide bounds; the random
    // calibrate items cannot narrow them, as they are already fully open.
    coeffs = '{16'd0, 16'hFFFF, 16'd32768, 16'($urandom_range(65535))};
    thrs   = '{16'd26214, 16'd0, 16'hFFFF, 16'($urandom_range(65535))};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(RegSmoothCoeff, coeffs[ph]);
      write_reg(RegWeightThr, thrs[ph]);
      send_gaps = (ph != 2);
      recv_stalls = (ph != 2);
      for (int n = 0; n < 210; n++) begin
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) pending_items.push_back(random_item(OpCalibrate));
        else if (pick < 25) pending_items.push_back(random_item(OpTrack));
        else begin
          // Bounds are all 0/4095 after the directed part; vary the samples
          // relative to them through the generator above.
          pending_items.push_back(line_item());
        end
        // Keep the predictor's bounds in step before building the next item.
        while (pending_items.size() > 0 || in_ch.valid) @(posedge clk_i);
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: filelist.f
design/lsct_pkg.sv
design/lsct_stream_if.sv
design/lsct_in_pkg.sv
design/line_sensor_centroid_tracker.sv
bench/line_sensor_centroid_tracker_test.sv
